@@ sv/fhs_pkg.sv @@
package fhs_pkg;

  localparam int MaxFrames = 256;
  localparam int CountW    = 9;
  localparam int CodeW     = 32;

  typedef enum logic [2:0] {
    OpPubProd  = 3'd0,
    OpPubCons  = 3'd1,
    OpPollProd = 3'd2,
    OpPollCons = 3'd3,
    OpFailProd = 3'd4,
    OpFailCons = 3'd5
  } op_e;

  typedef enum logic [2:0] {
    RcOk         = 3'd0,
    RcInvalid    = 3'd1,
    RcRange      = 3'd2,
    RcBusy       = 3'd3,
    RcProto      = 3'd4,
    RcWouldBlock = 3'd5,
    RcPeer       = 3'd6
  } rc_e;

  typedef struct packed {
    logic [2:0]              op;
    logic [CountW-1:0]       frame_number;
    logic [CountW-1:0]       after_frame;
    logic signed [CodeW-1:0] failure_code;
  } item_t;

  typedef struct packed {
    rc_e                     result_code;
    logic [CountW-1:0]       observed_frame;
    logic signed [CodeW-1:0] peer_code;
  } result_t;

  typedef struct packed {
    logic [CountW-1:0] produced_count;
    logic [CountW-1:0] consumed_count;
  } status_t;

  typedef struct packed {
    logic advance;
    logic stall;
  } in_ctrl_t;

endpackage

@@ sv/fhs_in_stage.sv @@
module fhs_in_stage (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  fhs_pkg::item_t   item_i,
  input  logic             out_free_i,
  output fhs_pkg::in_ctrl_t ctrl_o,
  output logic             vld_o,
  output fhs_pkg::item_t   item_o
);

  logic           vld_q, vld_d;
  fhs_pkg::item_t item_q;
  logic           accept;

  // The held beat moves on whenever the result register can take it.
  assign ctrl_o.advance = vld_q && out_free_i;
  assign ctrl_o.stall   = vld_q && !out_free_i;
  assign accept         = in_valid_i && !ctrl_o.stall;
  assign vld_d          = accept || (vld_q && !ctrl_o.advance);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_i;
    end
  end

  assign vld_o  = vld_q;
  assign item_o = item_q;

endmodule

@@ sv/fhs_engine.sv @@
module fhs_engine (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [fhs_pkg::CountW-1:0]    cfg_data_i,
  input  logic                          en_i,
  input  fhs_pkg::item_t                item_i,
  output fhs_pkg::result_t              result_o,
  output fhs_pkg::status_t              status_o
);

  localparam int W = fhs_pkg::CountW;

  logic [W-1:0] frame_limit_q;
  logic [W-1:0] prod_q, prod_d;
  logic [W-1:0] cons_q, cons_d;
  logic signed [fhs_pkg::CodeW-1:0] prod_fault_q, prod_fault_d;
  logic signed [fhs_pkg::CodeW-1:0] cons_fault_q, cons_fault_d;

  logic         cfg_ok;
  logic         peer_fail;
  logic signed [fhs_pkg::CodeW-1:0] peer_val;
  logic [W-1:0] current;
  logic [W-1:0] seq;
  logic         prod_seq_ok, cons_seq_ok;
  fhs_pkg::result_t res;

  assign seq    = item_i.frame_number;
  assign cfg_ok = (frame_limit_q != '0) &&
                  (frame_limit_q <= W'(fhs_pkg::MaxFrames));
  // The producer's stored failure takes precedence over the consumer's.
  assign peer_fail = prod_fault_q[fhs_pkg::CodeW-1] || cons_fault_q[fhs_pkg::CodeW-1];
  assign peer_val  = prod_fault_q[fhs_pkg::CodeW-1] ? prod_fault_q : cons_fault_q;
  assign current   = (item_i.op == fhs_pkg::OpPollProd) ? prod_q : cons_q;

  assign prod_seq_ok = (seq != '0) && (seq <= frame_limit_q) &&
                       ({1'b0, seq} == ({1'b0, prod_q} + (W+1)'(1)));
  assign cons_seq_ok = (seq != '0) && (seq <= frame_limit_q) &&
                       ({1'b0, seq} == ({1'b0, cons_q} + (W+1)'(1)));

  always_comb begin
    res.result_code    = fhs_pkg::RcInvalid;
    res.observed_frame = '0;
    res.peer_code      = '0;
    prod_d             = prod_q;
    cons_d             = cons_q;
    prod_fault_d       = prod_fault_q;
    cons_fault_d       = cons_fault_q;
    if (cfg_ok) begin
      case (item_i.op)
        fhs_pkg::OpPubProd: begin
          if (peer_fail) begin
            res.result_code = fhs_pkg::RcPeer;
            res.peer_code   = peer_val;
          end else if (!prod_seq_ok) begin
            res.result_code = fhs_pkg::RcRange;
          end else if (cons_q != prod_q) begin
            res.result_code = fhs_pkg::RcBusy;
          end else begin
            res.result_code = fhs_pkg::RcOk;
            prod_d          = seq;
          end
        end
        fhs_pkg::OpPubCons: begin
          if (peer_fail) begin
            res.result_code = fhs_pkg::RcPeer;
            res.peer_code   = peer_val;
          end else if (!cons_seq_ok) begin
            res.result_code = fhs_pkg::RcRange;
          end else if (prod_q != seq) begin
            res.result_code = fhs_pkg::RcBusy;
          end else begin
            res.result_code = fhs_pkg::RcOk;
            cons_d          = seq;
          end
        end
        fhs_pkg::OpPollProd, fhs_pkg::OpPollCons: begin
          if (item_i.after_frame > frame_limit_q) begin
            res.result_code = fhs_pkg::RcInvalid;
          end else if (peer_fail) begin
            res.result_code = fhs_pkg::RcPeer;
            res.peer_code   = peer_val;
          end else if (current > item_i.after_frame) begin
            res.result_code    = fhs_pkg::RcOk;
            res.observed_frame = current;
          end else if (current < item_i.after_frame) begin
            res.result_code = fhs_pkg::RcProto;
          end else begin
            res.result_code = fhs_pkg::RcWouldBlock;
          end
        end
        fhs_pkg::OpFailProd: begin
          if (item_i.failure_code[fhs_pkg::CodeW-1]) begin
            res.result_code = fhs_pkg::RcOk;
            prod_fault_d    = item_i.failure_code;
          end
        end
        fhs_pkg::OpFailCons: begin
          if (item_i.failure_code[fhs_pkg::CodeW-1]) begin
            res.result_code = fhs_pkg::RcOk;
            cons_fault_d    = item_i.failure_code;
          end
        end
        default: begin
          res.result_code = fhs_pkg::RcInvalid;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_limit_q <= W'(1);
      prod_q        <= '0;
      cons_q        <= '0;
      prod_fault_q  <= '0;
      cons_fault_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        frame_limit_q <= cfg_data_i;
      end
      if (en_i) begin
        prod_q       <= prod_d;
        cons_q       <= cons_d;
        prod_fault_q <= prod_fault_d;
        cons_fault_q <= cons_fault_d;
      end
    end
  end

  assign result_o                = res;
  assign status_o.produced_count = prod_q;
  assign status_o.consumed_count = cons_q;

endmodule

@@ sv/fhs_out_stage.sv @@
module fhs_out_stage (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  fhs_pkg::result_t result_i,
  input  logic             out_stall_i,
  output logic             free_o,
  output logic             out_valid_o,
  output fhs_pkg::result_t result_o
);

  logic             vld_q, vld_d;
  fhs_pkg::result_t result_q;

  assign free_o = !vld_q || !out_stall_i;
  assign vld_d  = load_i || (vld_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

  assign out_valid_o = vld_q;
  assign result_o    = result_q;

endmodule

@@ sv/frame_handshake_sync.sv @@
// Producer/consumer frame handshake engine.
// Input channel: one operation per beat (op_i, frame_number_i, after_frame_i,
// failure_code_i), taken at a clock edge where in_valid_i is high and
// in_stall_o is low. Output channel: one result per operation (result_code_o,
// observed_frame_o, peer_code_o), taken where out_valid_o is high and
// out_stall_i is low. Results come back in operation order.
// Configuration: the frame limit is written through cfg_data_i on an edge where
// cfg_valid_i and cfg_ready_o are high; cfg_ready_o is always high. Write it
// only while no operation is in flight.
// The checks and count updates run on the input register's contents, and the
// edge at which that beat advances loads the result register. Throughput is
// one operation per cycle while the receiver does not stall, since each
// operation needs only the counts left by the one before it.
// Reset clears both counts and both stored failure codes and sets the frame
// limit to one; no result is pending afterwards.
// While the receiver stalls, the result register holds its beat; the input
// register still takes one more operation, then in_stall_o rises until the
// result is taken.
module frame_handshake_sync (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [2:0]                        op_i,
  input  logic [fhs_pkg::CountW-1:0]        frame_number_i,
  input  logic [fhs_pkg::CountW-1:0]        after_frame_i,
  input  logic signed [fhs_pkg::CodeW-1:0]  failure_code_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [2:0]                        result_code_o,
  output logic [fhs_pkg::CountW-1:0]        observed_frame_o,
  output logic signed [fhs_pkg::CodeW-1:0]  peer_code_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [fhs_pkg::CountW-1:0]        cfg_data_i
);

  fhs_pkg::item_t    item_in, item_q;
  fhs_pkg::in_ctrl_t in_ctrl;
  fhs_pkg::result_t  result_d, result_q;
  fhs_pkg::status_t  status;
  logic              in_vld;
  logic              out_free;

  assign item_in.op           = op_i;
  assign item_in.frame_number = frame_number_i;
  assign item_in.after_frame  = after_frame_i;
  assign item_in.failure_code = failure_code_i;

  assign cfg_ready_o = 1'b1;

  fhs_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .item_i     (item_in),
    .out_free_i (out_free),
    .ctrl_o     (in_ctrl),
    .vld_o      (in_vld),
    .item_o     (item_q)
  );

  fhs_engine u_engine (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_valid_i && cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .en_i       (in_ctrl.advance),
    .item_i     (item_q),
    .result_o   (result_d),
    .status_o   (status)
  );

  fhs_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (in_ctrl.advance),
    .result_i    (result_d),
    .out_stall_i (out_stall_i),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .result_o    (result_q)
  );

  assign in_stall_o       = in_ctrl.stall;
  assign result_code_o    = 3'(result_q.result_code);
  assign observed_frame_o = result_q.observed_frame;
  assign peer_code_o      = result_q.peer_code;

  // The producer is never more than one frame ahead of the consumer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (status.produced_count == status.consumed_count) ||
    (status.produced_count == status.consumed_count + fhs_pkg::CountW'(1)))
    else $error("frame counts drifted apart");

  // Only a held result can push back on the input side.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && in_vld))
    else $error("input stalled without a pending result");

  // A peer-failed result always carries a negative stored code.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && result_q.result_code == fhs_pkg::RcPeer) |->
      peer_code_o[fhs_pkg::CodeW-1])
    else $error("peer failure without negative code");

  // A count is reported only with a successful poll.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && observed_frame_o != '0) |->
      (result_q.result_code == fhs_pkg::RcOk))
    else $error("observed frame on a non-ok result");

endmodule

@@ tb/sv/frame_handshake_sync_test.sv @@
`timescale 1ns / 1ps

module frame_handshake_sync_test;

  localparam int WatchdogLimit = 1000;
  localparam int HoldCycles    = 80;
  localparam int HoldAfter     = 300;

  // Op codes outside the defined set; the block answers them as invalid.
  localparam logic [2:0] OpSpare6 = 3'd6;
  localparam logic [2:0] OpSpare7 = 3'd7;

  typedef struct {
    fhs_pkg::item_t   it;
    bit               typed;
    fhs_pkg::result_t want;
  } step_row_t;

  logic                             clk            = 1'b0;
  logic                             rst_n          = 1'b0;
  logic                             in_valid       = 1'b0;
  logic                             in_stall;
  logic [2:0]                       op             = '0;
  logic [fhs_pkg::CountW-1:0]       frame_number   = '0;
  logic [fhs_pkg::CountW-1:0]       after_frame    = '0;
  logic signed [fhs_pkg::CodeW-1:0] failure_code   = '0;
  logic                             out_valid;
  logic                             out_stall      = 1'b0;
  logic [2:0]                       result_code;
  logic [fhs_pkg::CountW-1:0]       observed_frame;
  logic signed [fhs_pkg::CodeW-1:0] peer_code;
  logic                             cfg_valid      = 1'b0;
  logic                             cfg_ready;
  logic [fhs_pkg::CountW-1:0]       cfg_data       = '0;

  // Mirror of the block's state and its frame limit register.
  logic [fhs_pkg::CountW-1:0]       frames_cfg;
  logic [fhs_pkg::CountW-1:0]       produced;
  logic [fhs_pkg::CountW-1:0]       consumed;
  logic signed [fhs_pkg::CodeW-1:0] producer_fault;
  logic signed [fhs_pkg::CodeW-1:0] consumer_fault;

  fhs_pkg::result_t pending_results[$];
  step_row_t        directed[$];
  int               first_fault_row;
  int               errors     = 0;
  int               burst_left = 0;
  int               quiet      = 0;

  // Receiver stall pattern state.
  int stall_mode      = 0;
  int stall_mode_left = 0;
  int hold_left       = 0;
  int results_taken   = 0;
  bit hold_done       = 1'b0;

  frame_handshake_sync i_dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .op_i             (op),
    .frame_number_i   (frame_number),
    .after_frame_i    (after_frame),
    .failure_code_i   (failure_code),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .result_code_o    (result_code),
    .observed_frame_o (observed_frame),
    .peer_code_o      (peer_code),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready),
    .cfg_data_i       (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic step_row_t make_row(logic [2:0] o, int f, int a, int c, bit typed,
                                         fhs_pkg::rc_e rc, int obs, int peer);
    step_row_t r;
    r.it.op                 = o;
    r.it.frame_number       = f[fhs_pkg::CountW-1:0];
    r.it.after_frame        = a[fhs_pkg::CountW-1:0];
    r.it.failure_code       = c;
    r.typed                 = typed;
    r.want.result_code      = rc;
    r.want.observed_frame   = obs[fhs_pkg::CountW-1:0];
    r.want.peer_code        = peer;
    return r;
  endfunction

  // Computes the outcome of one operation and applies it to the mirrored state.
  function automatic fhs_pkg::result_t handshake_outcome(fhs_pkg::item_t it);
    fhs_pkg::result_t                 r;
    logic [fhs_pkg::CountW-1:0]       cur;
    logic signed [fhs_pkg::CodeW-1:0] fault;
    logic                             faulted;
    r.result_code    = fhs_pkg::RcInvalid;
    r.observed_frame = '0;
    r.peer_code      = '0;
    faulted = producer_fault[fhs_pkg::CodeW-1] | consumer_fault[fhs_pkg::CodeW-1];
    fault   = producer_fault[fhs_pkg::CodeW-1] ? producer_fault : consumer_fault;
    cur     = (it.op == fhs_pkg::OpPubProd || it.op == fhs_pkg::OpPollProd) ?
              produced : consumed;
    if (frames_cfg == 0 || frames_cfg > fhs_pkg::MaxFrames ||
        it.op > fhs_pkg::OpFailCons) begin
      r.result_code = fhs_pkg::RcInvalid;
    end else if (it.op == fhs_pkg::OpPubProd || it.op == fhs_pkg::OpPubCons) begin
      if (faulted) begin
        r.result_code = fhs_pkg::RcPeer;
        r.peer_code   = fault;
      end else if (it.frame_number == 0 || it.frame_number > frames_cfg ||
                   it.frame_number != cur + 1) begin
        r.result_code = fhs_pkg::RcRange;
      end else if (it.op == fhs_pkg::OpPubProd ? consumed != produced
                                               : produced != it.frame_number) begin
        r.result_code = fhs_pkg::RcBusy;
      end else begin
        r.result_code = fhs_pkg::RcOk;
        if (it.op == fhs_pkg::OpPubProd) begin
          produced = it.frame_number;
        end else begin
          consumed = it.frame_number;
        end
      end
    end else if (it.op == fhs_pkg::OpPollProd || it.op == fhs_pkg::OpPollCons) begin
      // The bound on after_frame is checked ahead of any stored failure.
      if (it.after_frame > frames_cfg) begin
        r.result_code = fhs_pkg::RcInvalid;
      end else if (faulted) begin
        r.result_code = fhs_pkg::RcPeer;
        r.peer_code   = fault;
      end else if (cur > it.after_frame) begin
        r.result_code    = fhs_pkg::RcOk;
        r.observed_frame = cur;
      end else if (cur < it.after_frame) begin
        r.result_code = fhs_pkg::RcProto;
      end else begin
        r.result_code = fhs_pkg::RcWouldBlock;
      end
    end else begin
      if (!it.failure_code[fhs_pkg::CodeW-1]) begin
        r.result_code = fhs_pkg::RcInvalid;
      end else begin
        r.result_code = fhs_pkg::RcOk;
        if (it.op == fhs_pkg::OpFailProd) begin
          producer_fault = it.failure_code;
        end else begin
          consumer_fault = it.failure_code;
        end
      end
    end
    return r;
  endfunction

  // A lockstep_pct share is the next publish of the lockstep exchange, some polls near the counts,
  // and the rest random noise.
  function automatic fhs_pkg::item_t random_item(int lockstep_pct, bit allow_fault);
    fhs_pkg::item_t             it;
    int                         pick;
    int                         a;
    logic [fhs_pkg::CountW-1:0] cur;
    it.op           = 3'($urandom_range(0, 7));
    it.frame_number = 9'($urandom);
    it.after_frame  = 9'($urandom);
    it.failure_code = $urandom;
    pick = $urandom_range(0, 99);
    if (pick < lockstep_pct) begin
      if (produced == consumed) begin
        it.op           = fhs_pkg::OpPubProd;
        it.frame_number = 9'(produced + 1);
      end else begin
        it.op           = fhs_pkg::OpPubCons;
        it.frame_number = produced;
      end
      // Now and then the wrong side publishes, which should come back busy or out of range.
      if ($urandom_range(0, 15) == 0) begin
        it.op = (it.op == fhs_pkg::OpPubProd) ? fhs_pkg::OpPubCons : fhs_pkg::OpPubProd;
      end
    end else if (pick < lockstep_pct + 12) begin
      it.op = $urandom_range(0, 1) ? fhs_pkg::OpPollProd : fhs_pkg::OpPollCons;
      cur   = (it.op == fhs_pkg::OpPollProd) ? produced : consumed;
      case ($urandom_range(0, 4))
        0: a = cur - 1;
        1: a = cur;
        2: a = cur + 1;
        3: a = $urandom_range(0, frames_cfg);
        default: a = frames_cfg + 1;
      endcase
      it.after_frame = 9'(a);
    end else if ($urandom_range(0, 3) != 0) begin
      it.after_frame = 9'($urandom_range(0, frames_cfg));
    end
    if (!allow_fault) begin
      it.failure_code[fhs_pkg::CodeW-1] = 1'b0;
    end
    return it;
  endfunction

  task automatic report_fault(string msg);
    errors++;
    if (errors <= 10) begin
      $display("%0t: %s", $time, msg);
    end
  endtask

  task automatic send_item(fhs_pkg::item_t it, bit typed, fhs_pkg::result_t want);
    int               idle;
    fhs_pkg::result_t predicted;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      idle       = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (idle > 0) begin
        in_valid <= 1'b0;
        repeat (idle) @(posedge clk);
      end
    end
    burst_left--;
    in_valid     <= 1'b1;
    op           <= it.op;
    frame_number <= it.frame_number;
    after_frame  <= it.after_frame;
    failure_code <= it.failure_code;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = handshake_outcome(it);
    pending_results.push_back(typed ? want : predicted);
  endtask

  task automatic walk_rows(int lo, int hi);
    for (int i = lo; i < hi; i++) begin
      send_item(directed[i].it, directed[i].typed, directed[i].want);
    end
  endtask

  task automatic run_random(int n, int lockstep_pct, bit allow_fault);
    fhs_pkg::result_t unused;
    unused = '0;
    for (int i = 0; i < n; i++) begin
      send_item(random_item(lockstep_pct, allow_fault), 1'b0, unused);
    end
  endtask

  // Stops offering beats and waits until every outstanding result is back.
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_frame_limit(int v);
    cfg_valid <= 1'b1;
    cfg_data  <= 9'(v);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    frames_cfg = 9'(v);
  endtask

  initial begin
    frames_cfg     = 9'd1;
    produced       = '0;
    consumed       = '0;
    producer_fault = '0;
    consumer_fault = '0;

    // Rows typed with an expectation hold with the frame limit at its reset value.
    directed.push_back(make_row(fhs_pkg::OpPollProd, 0, 0, 0, 1'b1,
                                fhs_pkg::RcWouldBlock, 0, 0));
    directed.push_back(make_row(fhs_pkg::OpPollCons, 0, 1, 0, 1'b1,
                                fhs_pkg::RcProto, 0, 0));
    directed.push_back(make_row(fhs_pkg::OpPollProd, 0, 511, 0, 1'b1,
                                fhs_pkg::RcInvalid, 0, 0));
    directed.push_back(make_row(fhs_pkg::OpPubCons, 1, 0, 0, 1'b1,
                                fhs_pkg::RcBusy, 0, 0));
    directed.push_back(make_row(fhs_pkg::OpPubProd, 0, 0, 0, 1'b1,
                                fhs_pkg::RcRange, 0, 0));
    directed.push_back(make_row(fhs_pkg::OpPubProd, 511, 0, 0, 1'b1,
                                fhs_pkg::RcRange, 0, 0));
    directed.push_back(make_row(fhs_pkg::OpPubProd, 1, 0, 0, 1'b1,
                                fhs_pkg::RcOk, 0, 0));
    directed.push_back(make_row(fhs_pkg::OpPubProd, 1, 0, 0, 1'b1,
                                fhs_pkg::RcRange, 0, 0));
    directed.push_back(make_row(fhs_pkg::OpPollProd, 0, 0, 0, 1'b1,
                                fhs_pkg::RcOk, 1, 0));
    directed.push_back(make_row(fhs_pkg::OpPubCons, 1, 0, 0, 1'b1,
                                fhs_pkg::RcOk, 0, 0));
    directed.push_back(make_row(fhs_pkg::OpPollCons, 0, 1, 0, 1'b0,
                                fhs_pkg::RcOk, 0, 0));
    directed.push_back(make_row(OpSpare6, 1, 1, -5, 1'b1,
                                fhs_pkg::RcInvalid, 0, 0));
    directed.push_back(make_row(OpSpare7, 511, 511, -1, 1'b1,
                                fhs_pkg::RcInvalid, 0, 0));
    directed.push_back(make_row(fhs_pkg::OpFailProd, 0, 0, 0, 1'b1,
                                fhs_pkg::RcInvalid, 0, 0));
    directed.push_back(make_row(fhs_pkg::OpFailCons, 0, 0, 32'h7fffffff, 1'b1,
                                fhs_pkg::RcInvalid, 0, 0));
    directed.push_back(make_row(fhs_pkg::OpPubProd, 2, 0, 0, 1'b0,
                                fhs_pkg::RcOk, 0, 0));
    // A stored failure is permanent, so these rows run only in the last phase, ahead of the faulting random run.
    first_fault_row = directed.size();
    directed.push_back(make_row(fhs_pkg::OpFailCons, 0, 0, -1, 1'b1,
                                fhs_pkg::RcOk, 0, 0));
    directed.push_back(make_row(fhs_pkg::OpPollProd, 0, 0, 0, 1'b1,
                                fhs_pkg::RcPeer, 0, -1));
    directed.push_back(make_row(fhs_pkg::OpFailProd, 0, 0, 32'h80000000, 1'b1,
                                fhs_pkg::RcOk, 0, 0));
    directed.push_back(make_row(fhs_pkg::OpPubCons, 1, 0, 0, 1'b1,
                                fhs_pkg::RcPeer, 0, 32'h80000000));
    directed.push_back(make_row(fhs_pkg::OpPollCons, 0, 257, 0, 1'b1,
                                fhs_pkg::RcInvalid, 0, 0));
    directed.push_back(make_row(fhs_pkg::OpFailProd, 0, 0, -2, 1'b1,
                                fhs_pkg::RcOk, 0, 0));
    directed.push_back(make_row(fhs_pkg::OpPubProd, 0, 0, 0, 1'b1,
                                fhs_pkg::RcPeer, 0, -2));
    directed.push_back(make_row(fhs_pkg::OpFailCons, 0, 0, 0, 1'b1,
                                fhs_pkg::RcInvalid, 0, 0));

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    walk_rows(0, first_fault_row);
    settle();
    write_frame_limit(0);
    run_random(30, 80, 1'b0);
    settle();
    write_frame_limit(511);
    run_random(30, 80, 1'b0);
    settle();
    write_frame_limit(fhs_pkg::MaxFrames + 1);
    run_random(20, 80, 1'b0);
    settle();
    write_frame_limit(fhs_pkg::MaxFrames);
    run_random(400, 82, 1'b0);
    settle();
    run_random(340, 82, 1'b0);
    settle();
    write_frame_limit(1);
    run_random(40, 60, 1'b0);
    settle();
    write_frame_limit(fhs_pkg::MaxFrames);
    walk_rows(first_fault_row, directed.size());
    run_random(60, 40, 1'b1);
    settle();

    if (errors == 0) begin
      $display("frame_handshake_sync verification clean");
    end else begin
      $display("frame_handshake_sync verification failed");
    end
    $finish;
  end

  always @(posedge clk) begin : check_results
    fhs_pkg::result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_fault($sformatf("result beat with nothing expected: rc=%0d obs=%0d peer=%0d",
                               result_code, observed_frame, peer_code));
      end else begin
        want = pending_results.pop_front();
        if (result_code !== want.result_code || observed_frame !== want.observed_frame ||
            peer_code !== want.peer_code) begin
          report_fault($sformatf("expected rc=%0d obs=%0d peer=%0d, got rc=%0d obs=%0d peer=%0d",
                                 want.result_code, want.observed_frame, want.peer_code,
                                 result_code, observed_frame, peer_code));
        end
      end
    end
  end

  // The receiver changes its stall mode now and then, and once it holds off
  // for a long stretch so that the block backs up into its input.
  always @(posedge clk) begin : stall_pattern
    logic stall_next;
    if (out_valid && !out_stall) begin
      results_taken++;
    end
    if (stall_mode_left == 0) begin
      stall_mode      = $urandom_range(0, 3);
      stall_mode_left = $urandom_range(20, 80);
    end
    stall_mode_left--;
    if (!hold_done && results_taken >= HoldAfter) begin
      hold_done = 1'b1;
      hold_left = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      stall_next = 1'b1;
    end else begin
      case (stall_mode)
        0: stall_next = 1'b0;
        1: stall_next = ($urandom_range(0, 99) < 30);
        2: stall_next = ($urandom_range(0, 99) < 80);
        default: stall_next = (stall_mode_left % 3 == 0);
      endcase
    end
    out_stall <= stall_next;
  end

  initial begin : watchdog
    while (quiet < WatchdogLimit) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("frame_handshake_sync verification failed");
    $finish;
  end

endmodule
